// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the frame delimiter.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MFD_ASSERT_IMP(label, ante, cons, msg) \
	`MFD_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/mfd_pkg.sv -----
// Types and constants of the MAVLink frame delimiter.
// No dependencies; used by mfd_decode and mavlink_frame_delimiter_top.
package mfd_pkg;

	localparam logic [7:0] MARK_V1      = 8'hFE;
	localparam logic [7:0] MARK_V2      = 8'hFD;
	localparam logic [8:0] OVERHEAD_V1  = 9'd8;
	localparam logic [8:0] OVERHEAD_V2  = 9'd12;
	localparam logic [8:0] SIGNED_EXTRA = 9'd13;
	localparam logic [7:0] SIGNED_FLAG  = 8'h01;
	localparam logic [8:0] LIMIT_RESET  = 9'd250;

	// Frame phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_FLAGS = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	// Tag of one output byte
	typedef enum logic [1:0] {
		KIND_DISCARD = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_DONE    = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	// Frame tracking state carried from byte to byte
	typedef struct packed {
		phase_t     phase;
		logic       second_version;
		logic [8:0] bytes_seen;
		logic [8:0] total_length;
	} frame_state_t;

	// One tagged output byte
	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      byte_kind;
		logic [8:0] byte_position;
		logic [8:0] frame_length;
	} result_t;

	localparam frame_state_t STATE_RESET = '{
		phase:          PH_HUNT,
		second_version: 1'b0,
		bytes_seen:     9'd0,
		total_length:   9'd0
	};

endpackage

// ----- rtl/mavlink_frame_delimiter_top.sv -----
// Top level of the MAVLink v1/v2 frame delimiter: registers, handshake, assertions.
// Depends on mfd_pkg, mfd_decode and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready/data_byte carries one serial byte per beat.
//   Output channel out_valid/out_ready carries out_byte, byte_kind,
//   byte_position and frame_length for every input byte, in order.
//   cfg_we/cfg_wdata write max_frame_bytes; write only when idle.
// Timing:
//   The output is registered: a byte accepted at an edge is presented at the
//   output from that edge on. Throughput is one byte per cycle while out_ready
//   is high; the decode and count of one byte sit between the frame state
//   register and the output register.
// Reset:
//   arst_n clears the frame state to hunting, empties the output register and
//   sets max_frame_bytes to 250.
// Stall:
//   While out_ready is low the output beat holds and in_ready drops; a new
//   byte is taken in the same cycle the held beat leaves.
`include "assert_macros.svh"

module mavlink_frame_delimiter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] byte_kind,
	output logic [8:0] byte_position,
	output logic [8:0] frame_length
);

	mfd_pkg::frame_state_t state_q;
	mfd_pkg::frame_state_t state_nxt;
	mfd_pkg::result_t      res_nxt;
	mfd_pkg::result_t      res_q;
	logic [8:0]            max_frame_q;
	logic                  out_valid_q;
	logic                  in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	mfd_decode u_decode (
		.cur             (state_q),
		.data_byte       (data_byte),
		.max_frame_bytes (max_frame_q),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	// Hold the byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= mfd_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			max_frame_q <= cfg_wdata;
		end
	end

	// Advance frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfd_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	// Load the output register on accept
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = res_q.out_byte;
	assign byte_kind     = res_q.byte_kind;
	assign byte_position = res_q.byte_position;
	assign frame_length  = res_q.frame_length;

	// Checks
	`MFD_ASSERT_IMP(a_hunt_clear, state_q.phase == mfd_pkg::PH_HUNT,
		(state_q.bytes_seen == 9'd0) && (state_q.total_length == 9'd0),
		"hunting with stale frame counters")
	`MFD_ASSERT_IMP(a_discard_zero, out_valid_q && (res_q.byte_kind == mfd_pkg::KIND_DISCARD),
		(res_q.byte_position == 9'd0) && (res_q.frame_length == 9'd0),
		"discarded byte carries frame position or length")
	`MFD_ASSERT_IMP(a_done_last, out_valid_q && (res_q.byte_kind == mfd_pkg::KIND_DONE),
		(res_q.byte_position + 9'd1) == res_q.frame_length,
		"complete tag not on the last byte of the frame")
	`MFD_ASSERT(a_done_rehunt,
		(in_fire && (res_nxt.byte_kind == mfd_pkg::KIND_DONE)) |=>
		(state_q.phase == mfd_pkg::PH_HUNT),
		"frame completed without returning to hunt")

endmodule

// ----- rtl/mfd_decode.sv -----
// Per-byte header decode, counting and tagging of the frame delimiter.
// Pure combinational; depends on mfd_pkg.
module mfd_decode (
	input  mfd_pkg::frame_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic [8:0]            max_frame_bytes,
	output mfd_pkg::frame_state_t nxt,
	output mfd_pkg::result_t      res
);

	mfd_pkg::frame_state_t st;
	logic [9:0]            count;
	logic                  known;
	logic                  is_marker;
	mfd_pkg::kind_t        kind;

	// Advance the header phase for this byte
	always_comb begin
		st        = cur;
		is_marker = (data_byte == mfd_pkg::MARK_V1) || (data_byte == mfd_pkg::MARK_V2);
		unique case (cur.phase)
			mfd_pkg::PH_HUNT: begin
				if (is_marker) begin
					st.second_version = (data_byte == mfd_pkg::MARK_V2);
					st.bytes_seen     = 9'd0;
					st.total_length   = 9'd0;
					st.phase          = mfd_pkg::PH_LEN;
				end
			end
			mfd_pkg::PH_LEN: begin
				if (cur.second_version) begin
					st.total_length = {1'b0, data_byte} + mfd_pkg::OVERHEAD_V2;
					st.phase        = mfd_pkg::PH_FLAGS;
				end else begin
					st.total_length = {1'b0, data_byte} + mfd_pkg::OVERHEAD_V1;
					st.phase        = mfd_pkg::PH_BODY;
				end
			end
			mfd_pkg::PH_FLAGS: begin
				if ((data_byte & mfd_pkg::SIGNED_FLAG) != 8'd0) begin
					st.total_length = cur.total_length + mfd_pkg::SIGNED_EXTRA;
				end
				st.phase = mfd_pkg::PH_BODY;
			end
			mfd_pkg::PH_BODY: begin
				st = cur;
			end
			default: begin
				st = cur;
			end
		endcase
	end

	// Tag the byte: completion wins over the byte limit
	always_comb begin
		count = {1'b0, st.bytes_seen} + 10'd1;
		known = (st.phase == mfd_pkg::PH_BODY);
		if (known && (count >= {1'b0, st.total_length})) begin
			kind = mfd_pkg::KIND_DONE;
		end else if (count >= {1'b0, max_frame_bytes}) begin
			kind = mfd_pkg::KIND_ABORT;
		end else begin
			kind = mfd_pkg::KIND_FRAME;
		end
	end

	// Build next state and result; a non-marker while hunting is dropped
	always_comb begin
		res.out_byte = data_byte;
		if ((cur.phase == mfd_pkg::PH_HUNT) && !is_marker) begin
			nxt               = cur;
			res.byte_kind     = mfd_pkg::KIND_DISCARD;
			res.byte_position = 9'd0;
			res.frame_length  = 9'd0;
		end else begin
			res.byte_kind     = kind;
			res.byte_position = st.bytes_seen;
			res.frame_length  = known ? st.total_length : 9'd0;
			if (kind == mfd_pkg::KIND_FRAME) begin
				nxt            = st;
				nxt.bytes_seen = count[8:0];
			end else begin
				nxt = mfd_pkg::STATE_RESET;
			end
		end
	end

endmodule

// ----- bench/mavlink_frame_delimiter_top_tb.sv -----
// Self-checking bench for mavlink_frame_delimiter_top: byte tagging, frame length
// decode and abort limit, checked beat by beat against an in-bench tag predictor.
// Depends on mfd_pkg and the RTL of the frame delimiter only.
module mavlink_frame_delimiter_top_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_BYTES = 85;
	localparam int unsigned NUM_PHASES  = 10;
	localparam int unsigned HOLD_AFTER  = 300;
	localparam int unsigned HOLD_CYCLES = 200;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic [8:0] byte_position;
	logic [8:0] frame_length;

	// One row of the directed table; the expectation is used only when fixed is set
	typedef struct {
		logic [7:0]     b;
		bit             fixed;
		mfd_pkg::kind_t kind;
		logic [8:0]     pos;
		logic [8:0]     flen;
	} dir_row_t;

	dir_row_t              dir_tab [25];
	mfd_pkg::result_t      pending_tags [$];
	logic [7:0]            line_bytes [$];
	mfd_pkg::frame_state_t trk;
	logic [8:0]            trk_limit;
	int unsigned           burst_left;
	int unsigned           mism;
	int unsigned           rx_count;
	int unsigned           n_disc;
	int unsigned           n_body;
	int unsigned           n_done;
	int unsigned           n_abort;
	int unsigned           cycle_cnt;

	mavlink_frame_delimiter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_kind     (byte_kind),
		.byte_position (byte_position),
		.frame_length  (frame_length)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Tag one byte and advance the predicted frame state
	function automatic mfd_pkg::result_t tag_byte(input logic [7:0] b);
		mfd_pkg::result_t r;
		logic [9:0]       count;
		logic             known;
		r.out_byte      = b;
		r.byte_kind     = mfd_pkg::KIND_FRAME;
		r.byte_position = '0;
		r.frame_length  = '0;
		case (trk.phase)
			mfd_pkg::PH_HUNT: begin
				if (b != mfd_pkg::MARK_V1 && b != mfd_pkg::MARK_V2) begin
					r.byte_kind = mfd_pkg::KIND_DISCARD;
					return r;
				end
				trk.second_version = (b == mfd_pkg::MARK_V2);
				trk.bytes_seen     = '0;
				trk.total_length   = '0;
				trk.phase          = mfd_pkg::PH_LEN;
			end
			mfd_pkg::PH_LEN: begin
				if (trk.second_version) begin
					trk.total_length = {1'b0, b} + mfd_pkg::OVERHEAD_V2;
					trk.phase        = mfd_pkg::PH_FLAGS;
				end else begin
					trk.total_length = {1'b0, b} + mfd_pkg::OVERHEAD_V1;
					trk.phase        = mfd_pkg::PH_BODY;
				end
			end
			mfd_pkg::PH_FLAGS: begin
				if ((b & mfd_pkg::SIGNED_FLAG) != 8'h00)
					trk.total_length = trk.total_length + mfd_pkg::SIGNED_EXTRA;
				trk.phase = mfd_pkg::PH_BODY;
			end
			default: ;
		endcase
		r.byte_position = trk.bytes_seen;
		count           = {1'b0, trk.bytes_seen} + 10'd1;
		known           = (trk.phase == mfd_pkg::PH_BODY);
		r.frame_length  = known ? trk.total_length : 9'd0;
		// completion wins over the limit on the same byte
		if (known && count >= {1'b0, trk.total_length})
			r.byte_kind = mfd_pkg::KIND_DONE;
		else if (count >= {1'b0, trk_limit})
			r.byte_kind = mfd_pkg::KIND_ABORT;
		if (r.byte_kind == mfd_pkg::KIND_FRAME) begin
			trk.bytes_seen = count[8:0];
		end else begin
			trk = mfd_pkg::STATE_RESET;
		end
		return r;
	endfunction

	// Offer one beat in bursts with random gaps, hold it until taken, then predict
	task automatic offer_byte(input logic [7:0] b, output mfd_pkg::result_t pred);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = 60;
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(0, 5);
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		pred = tag_byte(b);
	endtask

	// Drain every pending tag, let the pipe settle, then write the limit
	task automatic set_limit(input logic [8:0] v);
		in_valid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		trk_limit = v;
	endtask

	// Fill the byte queue with mostly well-formed frames, some noise and cut frames
	task automatic build_stream(input int unsigned n);
		int unsigned sel;
		int unsigned plen;
		int unsigned total;
		int unsigned body;
		logic [7:0]  flags;
		bit          v2;
		while (line_bytes.size() < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom));
			end else begin
				v2  = 1'($urandom_range(0, 1));
				sel = $urandom_range(0, 99);
				if (sel < 80)
					plen = $urandom_range(0, 24);
				else if (sel < 95 || trk_limit < 200)
					plen = $urandom_range(25, 80);
				else
					plen = $urandom_range(200, 255);
				flags = 8'($urandom);
				total = plen + (v2 ? (12 + (flags[0] ? 13 : 0)) : 8);
				line_bytes.push_back(v2 ? mfd_pkg::MARK_V2 : mfd_pkg::MARK_V1);
				line_bytes.push_back(8'(plen));
				if (v2)
					line_bytes.push_back(flags);
				body = total - (v2 ? 3 : 2);
				// cut a frame short now and then; the next bytes land inside it
				if ($urandom_range(0, 9) == 0)
					body = $urandom_range(0, body);
				repeat (body) line_bytes.push_back(8'($urandom));
			end
		end
		// trim to the requested count; an open frame runs on into the next setting
		while (line_bytes.size() > n) void'(line_bytes.pop_back());
	endtask

	// Receiver: ready pattern that changes mode, plus one long hold-off
	initial begin : out_side
		int unsigned tick;
		int unsigned mode;
		int unsigned hold_cnt;
		bit          hold_done;
		tick      = 0;
		mode      = 0;
		hold_cnt  = 0;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (!hold_done && rx_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_cnt  = HOLD_CYCLES;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (tick % 4) != 0;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
			if (tick % 64 == 0)
				mode = $urandom_range(0, 3);
		end
	end

	// Compare each output beat with the oldest pending tag
	always @(posedge clk) begin : out_check
		mfd_pkg::result_t got;
		mfd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			got.out_byte      = out_byte;
			got.byte_kind     = mfd_pkg::kind_t'(byte_kind);
			got.byte_position = byte_position;
			got.frame_length  = frame_length;
			rx_count++;
			case (got.byte_kind)
				mfd_pkg::KIND_DISCARD: n_disc++;
				mfd_pkg::KIND_FRAME:   n_body++;
				mfd_pkg::KIND_DONE:    n_done++;
				default:               n_abort++;
			endcase
			if (pending_tags.size() == 0) begin
				mism++;
				if (mism <= 10)
					$display("beat %0d: unexpected output byte %h kind %0d pos %0d len %0d",
						rx_count, got.out_byte, got.byte_kind, got.byte_position,
						got.frame_length);
			end else begin
				want = pending_tags.pop_front();
				if (got.out_byte !== want.out_byte || got.byte_kind !== want.byte_kind ||
					got.byte_position !== want.byte_position ||
					got.frame_length !== want.frame_length) begin
					mism++;
					if (mism <= 10)
						$display("beat %0d: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
							rx_count, want.out_byte, want.byte_kind, want.byte_position,
							want.frame_length, got.out_byte, got.byte_kind,
							got.byte_position, got.frame_length);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tags pending", cycle_cnt,
				pending_tags.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stim
		mfd_pkg::result_t pred;
		mfd_pkg::result_t want;
		logic [8:0]       lims [NUM_PHASES];
		int unsigned      n_sent;
		lims = '{9'd8, 9'd280, 9'd0, 9'd1, 9'd511, 9'd12, 9'd25,
			9'($urandom_range(8, 280)), 9'($urandom_range(0, 511)), 9'd250};
		// known frames: v1 minimum, v2 minimum, v2 signed at full length
		dir_tab = '{
			'{8'h00, 1'b1, mfd_pkg::KIND_DISCARD, 9'd0,  9'd0},
			'{8'hFF, 1'b1, mfd_pkg::KIND_DISCARD, 9'd0,  9'd0},
			'{8'hFE, 1'b1, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h00, 1'b1, mfd_pkg::KIND_FRAME,   9'd1,  9'd8},
			'{8'hFE, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hFD, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h55, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hAA, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h00, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h7F, 1'b1, mfd_pkg::KIND_DONE,    9'd7,  9'd8},
			'{8'hFD, 1'b1, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h00, 1'b1, mfd_pkg::KIND_FRAME,   9'd1,  9'd0},
			'{8'h00, 1'b1, mfd_pkg::KIND_FRAME,   9'd2,  9'd12},
			'{8'h01, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hFE, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hFD, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hFF, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h80, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h7F, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h0F, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hF0, 1'b0, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'h80, 1'b1, mfd_pkg::KIND_DONE,    9'd11, 9'd12},
			'{8'hFD, 1'b1, mfd_pkg::KIND_FRAME,   9'd0,  9'd0},
			'{8'hFF, 1'b1, mfd_pkg::KIND_FRAME,   9'd1,  9'd0},
			'{8'hFF, 1'b1, mfd_pkg::KIND_FRAME,   9'd2,  9'd280}
		};
		trk        = mfd_pkg::STATE_RESET;
		trk_limit  = mfd_pkg::LIMIT_RESET;
		burst_left = 0;
		mism       = 0;
		rx_count   = 0;
		n_disc     = 0;
		n_body     = 0;
		n_done     = 0;
		n_abort    = 0;
		n_sent     = 0;
		cycle_cnt  <= 0;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		data_byte  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset limit; the last frame stays open into phase one
		foreach (dir_tab[i]) begin
			offer_byte(dir_tab[i].b, pred);
			if (dir_tab[i].fixed) begin
				want.out_byte      = dir_tab[i].b;
				want.byte_kind     = dir_tab[i].kind;
				want.byte_position = dir_tab[i].pos;
				want.frame_length  = dir_tab[i].flen;
				pending_tags.push_back(want);
			end else begin
				pending_tags.push_back(pred);
			end
			n_sent++;
		end

		// Random frames under a sweep of limits
		foreach (lims[p]) begin
			set_limit(lims[p]);
			build_stream(PHASE_BYTES);
			while (line_bytes.size() != 0) begin
				offer_byte(line_bytes.pop_front(), pred);
				pending_tags.push_back(pred);
				n_sent++;
			end
		end

		in_valid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d bytes over %0d limit settings, %0d beats back", n_sent,
			NUM_PHASES + 1, rx_count);
		$display("tags seen: %0d discarded, %0d in frame, %0d complete, %0d aborted",
			n_disc, n_body, n_done, n_abort);
		if (mism == 0 && pending_tags.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d tags left", mism, pending_tags.size());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
